@@ rtl/core/hkvt_pkg.sv @@
// Package for the hash key-value table: sizes, request and status codes, way-match struct.
package hkvt_pkg;

  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int BUCKETS     = 64;   // power of two: the bucket is the key's low bits
  localparam int WAYS        = 4;
  localparam int BUCKET_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_SPARE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic                has_free;
    logic [WAY_BITS-1:0] free_way;
  } match_t;

endpackage

@@ rtl/core/hkvt_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module hkvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/hkvt_match.sv @@
// Parallel way compare: first matching valid way and first free way of a bucket row.
module hkvt_match
  import hkvt_pkg::*;
(
  input  logic [WAYS-1:0]          row_valid,
  input  logic [WAYS*KEY_BITS-1:0] row_keys,
  input  logic [KEY_BITS-1:0]      key,
  output match_t                   match
);

  always_comb begin
    match = '0;
    // walk down so the lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_valid[w] && (row_keys[w*KEY_BITS +: KEY_BITS] == key)) begin
        match.hit     = 1'b1;
        match.hit_way = WAY_BITS'(w);
      end
      if (!row_valid[w]) begin
        match.has_free = 1'b1;
        match.free_way = WAY_BITS'(w);
      end
    end
  end

endmodule

@@ rtl/core/hash_key_value_table.sv @@
// Hash key-value table: lookup, add and remove over BUCKETS buckets of WAYS ways.
// The result is registered at the end of the compare state (S_EVAL) that follows the accept edge.
// No new request is taken while one is in S_EVAL or while a held result is stalled by out_stall;
// the key/value RAM bucket row is read in the accept cycle, compared and written back in the next.
// Reset clears all valid flags; key and value RAMs need no clearing pass.
module hash_key_value_table
  import hkvt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] read_value,
  output logic [1:0]  status
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t                   state, state_next;
  logic [1:0]               req_q;
  logic [KEY_BITS-1:0]      key_q;
  logic [VALUE_BITS-1:0]    value_q;
  logic [BUCKET_BITS-1:0]   bucket_q;
  logic [WAYS-1:0]          valid_q [BUCKETS];
  logic [WAYS-1:0]          row_valid;
  logic [BUCKET_BITS-1:0]   ram_addr;
  logic [WAYS*KEY_BITS-1:0] key_row, key_row_next;
  logic [WAYS*VALUE_BITS-1:0] val_row, val_row_next;
  logic                     accept;
  logic                     do_add;
  logic                     do_remove;
  match_t                   match;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign ram_addr = (state == S_IDLE) ? key[BUCKET_BITS-1:0] : bucket_q;
  assign row_valid = valid_q[bucket_q];

  hkvt_match u_match (
    .row_valid (row_valid),
    .row_keys  (key_row),
    .key       (key_q),
    .match     (match)
  );

  assign do_add    = (state == S_EVAL) && (req_q == REQ_ADD) && !match.hit
                     && match.has_free;
  assign do_remove = (state == S_EVAL) && (req_q == REQ_REMOVE) && match.hit;

  // replace only the free way; other ways write back what was read
  always_comb begin
    key_row_next = key_row;
    val_row_next = val_row;
    key_row_next[match.free_way*KEY_BITS +: KEY_BITS]     = key_q;
    val_row_next[match.free_way*VALUE_BITS +: VALUE_BITS] = value_q;
  end

  hkvt_ram #(.WIDTH(WAYS*KEY_BITS), .DEPTH(BUCKETS)) u_key_ram (
    .clk   (clk),
    .we    (do_add),
    .addr  (ram_addr),
    .wdata (key_row_next),
    .rdata (key_row)
  );

  hkvt_ram #(.WIDTH(WAYS*VALUE_BITS), .DEPTH(BUCKETS)) u_val_ram (
    .clk   (clk),
    .we    (do_add),
    .addr  (ram_addr),
    .wdata (val_row_next),
    .rdata (val_row)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the request for the compare cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q    <= req_type;
      key_q    <= KEY_BITS'(key);
      value_q  <= VALUE_BITS'(value);
      bucket_q <= key[BUCKET_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BUCKETS; b++) begin
        valid_q[b] <= '0;
      end
    end else if (do_add) begin
      valid_q[bucket_q][match.free_way] <= 1'b1;
    end else if (do_remove) begin
      valid_q[bucket_q][match.hit_way] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EVAL) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      found      <= match.hit;
      read_value <= '0;
      case (req_q)
        REQ_ADD: begin
          if (match.hit) begin
            status <= ST_DUP;
          end else if (!match.has_free) begin
            status <= ST_FULL;
          end else begin
            status <= ST_OK;
          end
        end
        REQ_REMOVE: begin
          status <= match.hit ? ST_OK : ST_MISS;
        end
        default: begin
          status <= match.hit ? ST_OK : ST_MISS;
          if (match.hit) begin
            read_value <= 32'(val_row[match.hit_way*VALUE_BITS +: VALUE_BITS]);
          end
        end
      endcase
    end
  end

endmodule

@@ bench/hash_key_value_table_test.sv @@
// Self-checking bench for hash_key_value_table: directed and random request traffic.
`timescale 1ns / 1ps

class kv_table_tracker;
  localparam int ENTRIES = hkvt_pkg::BUCKETS * hkvt_pkg::WAYS;

  typedef struct {
    logic                    found;
    logic [31:0]             read_value;
    hkvt_pkg::status_t       status;
  } reply_t;

  bit          slot_used [ENTRIES];
  logic [31:0] slot_key  [ENTRIES];
  logic [31:0] slot_value[ENTRIES];
  reply_t      pending_replies[$];
  int          failures;

  function new();
    failures = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  endfunction

  // Apply one request to the table copy and queue the reply it must produce.
  function void note_request(hkvt_pkg::req_t req, logic [31:0] k, logic [31:0] v);
    int     base;
    int     hit_idx;
    int     free_idx;
    bit     hit;
    bit     has_free;
    reply_t rep;
    base     = int'(k % hkvt_pkg::BUCKETS) * hkvt_pkg::WAYS;
    hit      = 1'b0;
    has_free = 1'b0;
    hit_idx  = 0;
    free_idx = 0;
    for (int w = 0; w < hkvt_pkg::WAYS; w++) begin
      if (slot_used[base + w]) begin
        if (!hit && slot_key[base + w] == k) begin
          hit     = 1'b1;
          hit_idx = base + w;
        end
      end else if (!has_free) begin
        has_free = 1'b1;
        free_idx = base + w;
      end
    end
    rep.found      = 1'b0;
    rep.read_value = '0;
    rep.status     = hkvt_pkg::ST_OK;
    case (req)
      hkvt_pkg::REQ_ADD: begin
        if (hit) begin
          rep.found  = 1'b1;
          rep.status = hkvt_pkg::ST_DUP;
        end else if (!has_free) begin
          rep.status = hkvt_pkg::ST_FULL;
        end else begin
          slot_used[free_idx]  = 1'b1;
          slot_key[free_idx]   = k;
          slot_value[free_idx] = v;
        end
      end
      hkvt_pkg::REQ_REMOVE: begin
        if (hit) begin
          slot_used[hit_idx] = 1'b0;
          rep.found          = 1'b1;
        end else begin
          rep.status = hkvt_pkg::ST_MISS;
        end
      end
      default: begin
        // lookup, and the spare code behaves the same
        if (hit) begin
          rep.found      = 1'b1;
          rep.read_value = slot_value[hit_idx];
        end else begin
          rep.status = hkvt_pkg::ST_MISS;
        end
      end
    endcase
    pending_replies.push_back(rep);
  endfunction

  function void check_reply(logic f, logic [31:0] rv, logic [1:0] st);
    reply_t exp_rep;
    if (pending_replies.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: reply with none pending: found %b read_value %h status %0d",
                 $time, f, rv, st);
      return;
    end
    exp_rep = pending_replies.pop_front();
    if (f !== exp_rep.found || rv !== exp_rep.read_value || st !== exp_rep.status) begin
      failures++;
      if (failures <= 10)
        $display("%0t: reply mismatch: expected found %b read_value %h status %0d,",
                 $time, exp_rep.found, exp_rep.read_value, exp_rep.status,
                 " got found %b read_value %h status %0d", f, rv, st);
    end
  endfunction
endclass

module hash_key_value_table_test;
  import hkvt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [31:0] key;
  logic [31:0] value;
  logic        out_valid;
  logic        out_stall;
  logic        found;
  logic [31:0] read_value;
  logic [1:0]  status;

  kv_table_tracker table_copy;
  bit              idling_on;
  int              cycle_count;
  int              stall_left;
  logic [31:0]     key_uppers[6];
  int              hot_buckets[5];

  hash_key_value_table DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .read_value (read_value),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hash_key_value_table regression: fail");
      $finish;
    end
  end

  // Note accepted requests before checking replies; both sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        table_copy.note_request(req_t'(req_type), key, value);
      if (out_valid && !out_stall)
        table_copy.check_reply(found, read_value, status);
    end
  end

  // Receiver back-pressure: random stall runs, mostly short.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idling_on && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one beat and hold it until accepted. Valid stays high into the
  // next beat when there is no gap.
  task automatic send_request(input req_t req, input logic [31:0] k, input logic [31:0] v);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = req;
    key      = k;
    value    = v;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] pick_key();
    int bkt;
    if ($urandom_range(0, 99) < 12) return $urandom();
    bkt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, BUCKETS - 1)
                                      : hot_buckets[$urandom_range(0, 4)];
    return (key_uppers[$urandom_range(0, 5)] << BUCKET_BITS) | bkt;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  task automatic random_phase(input int n, input int add_weight);
    int   r;
    req_t req;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < add_weight)           req = REQ_ADD;
      else if (r < add_weight + 30) req = REQ_LOOKUP;
      else if (r < 95)              req = REQ_REMOVE;
      else                          req = REQ_SPARE;
      send_request(req, pick_key(), pick_value());
    end
  endtask

  task automatic drain_replies();
    while (table_copy.pending_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    table_copy  = new();
    cycle_count = 0;
    stall_left  = 0;
    idling_on   = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    req_type    = REQ_LOOKUP;
    key         = '0;
    value       = '0;
    out_stall   = 1'b0;
    key_uppers[0] = '0;
    key_uppers[1] = 32'h03FF_FFFF;
    for (int i = 2; i < 6; i++) key_uppers[i] = $urandom_range(1, 32'h03FF_FFFE);
    hot_buckets[0] = 0;
    hot_buckets[1] = BUCKETS - 1;
    for (int i = 2; i < 5; i++) hot_buckets[i] = $urandom_range(1, BUCKETS - 2);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty miss, duplicate, bucket fill, full, reuse of freed way, spare code.
    send_request(REQ_LOOKUP, 32'h0,         32'h0);
    send_request(REQ_ADD,    32'h0,         32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'h0,         32'h0);
    send_request(REQ_ADD,    32'h0,         32'h1234_5678);
    send_request(REQ_ADD,    32'd64,        32'h0000_0001);
    send_request(REQ_ADD,    32'd128,       32'h0000_0002);
    send_request(REQ_ADD,    32'd192,       32'h0000_0003);
    send_request(REQ_ADD,    32'd256,       32'h0000_0004);
    send_request(REQ_LOOKUP, 32'd256,       32'h0);
    send_request(REQ_REMOVE, 32'd128,       32'h0);
    send_request(REQ_ADD,    32'd256,       32'hA5A5_5A5A);
    send_request(REQ_LOOKUP, 32'd256,       32'h0);
    send_request(REQ_LOOKUP, 32'd192,       32'h0);
    send_request(REQ_REMOVE, 32'd999,       32'h0);
    send_request(REQ_SPARE,  32'h0,         32'hDEAD_BEEF);
    send_request(REQ_SPARE,  32'd5,         32'h0);
    send_request(REQ_ADD,    32'hFFFF_FFFF, 32'h0);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_ADD,    32'h7FFF_FFFF, 32'h8000_0000);
    send_request(REQ_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_REMOVE, 32'h0,         32'h0);
    send_request(REQ_LOOKUP, 32'h0,         32'h0);

    // Random: alternate back-to-back traffic with idling on both sides.
    random_phase(300, 45);
    idling_on = 1'b1;
    random_phase(500, 40);
    idling_on = 1'b0;
    random_phase(300, 25);
    idling_on = 1'b1;
    random_phase(500, 35);
    idling_on = 1'b0;
    random_phase(300, 40);

    @(negedge clk);
    in_valid = 1'b0;
    drain_replies();
    repeat (20) @(posedge clk);
    if (table_copy.failures == 0)
      $display("hash_key_value_table regression: pass");
    else
      $display("hash_key_value_table regression: fail");
    $finish;
  end

endmodule
